/* sv/assert_macros.svh */
// Assertion macros shared by the deadline tracking table RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DTT_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define DTT_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define DTT_ASSERT_IMPL(label, clk, rst_n, a, b)
`define DTT_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

/* sv/dtt_pkg.sv */
// Shared types and constants of the deadline tracking table.
// No dependencies.
`default_nettype none
package dtt_pkg;
    localparam int TABLE_DEPTH_DEF     = 64;
    localparam int SUBSYSTEM_COUNT_DEF = 8;
    localparam int SOURCE_COUNT        = 5;

    typedef enum logic [2:0] {
        KIND_ANNOUNCE = 3'd0,
        KIND_SATISFY  = 3'd1,
        KIND_TICK     = 3'd2,
        KIND_QUERY    = 3'd3,
        KIND_RETIRE   = 3'd4,
        KIND_STATS    = 3'd5
    } t_kind;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_SRC = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    typedef struct packed {
        logic [2:0]  subsystem;
        logic [63:0] region;
        logic [31:0] due;
        logic [15:0] confidence;
        logic [2:0]  source;
        logic        satisfied;
        logic        missed;
    } t_entry;

    // Counter update requests from the sequencer.
    typedef struct packed {
        logic       inc_set;
        logic [2:0] set_src;
        logic       inc_met;
        logic [2:0] met_src;
        logic       inc_miss;
        logic [2:0] miss_src;
        logic [2:0] miss_sub;
    } t_cnt_cmd;
endpackage
`default_nettype wire

/* sv/dtt_entry_ram.sv */
// Entry memory: one write port, one read port with registered data.
// Depends on dtt_pkg for the entry type.
`default_nettype none
module dtt_entry_ram #(
    parameter int DEPTH = dtt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire dtt_pkg::t_entry          i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output dtt_pkg::t_entry               o_rd_data
);
    import dtt_pkg::*;

    t_entry r_mem [DEPTH];

    // Synchronous write and read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule
`default_nettype wire

/* sv/dtt_counters.sv */
// Wrapping per-source and per-subsystem statistics counters.
// Depends on dtt_pkg for the command struct and source count.
`default_nettype none
module dtt_counters #(
    parameter int SUBSYSTEM_COUNT = dtt_pkg::SUBSYSTEM_COUNT_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dtt_pkg::t_cnt_cmd i_cmd,
    input  wire logic [2:0]        i_stat_src,
    input  wire logic [2:0]        i_stat_sub,
    output logic [31:0]            o_set_count,
    output logic [31:0]            o_met_count,
    output logic [31:0]            o_missed_count,
    output logic [31:0]            o_subsystem_misses
);
    import dtt_pkg::*;

    localparam logic [2:0] SRC_LIMIT = 3'(SOURCE_COUNT);
    localparam logic [3:0] SUB_LIMIT = 4'(SUBSYSTEM_COUNT);

    logic [31:0] r_set  [SOURCE_COUNT];
    logic [31:0] r_met  [SOURCE_COUNT];
    logic [31:0] r_miss [SOURCE_COUNT];
    logic [31:0] r_sub  [8];

    // Increment on request, clear on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SOURCE_COUNT; k++) begin
                r_set[k]  <= '0;
                r_met[k]  <= '0;
                r_miss[k] <= '0;
            end
            for (int k = 0; k < 8; k++) begin
                r_sub[k] <= '0;
            end
        end else begin
            if (i_cmd.inc_set && i_cmd.set_src < SRC_LIMIT) begin
                r_set[i_cmd.set_src] <= r_set[i_cmd.set_src] + 32'd1;
            end
            if (i_cmd.inc_met && i_cmd.met_src < SRC_LIMIT) begin
                r_met[i_cmd.met_src] <= r_met[i_cmd.met_src] + 32'd1;
            end
            if (i_cmd.inc_miss) begin
                if (i_cmd.miss_src < SRC_LIMIT) begin
                    r_miss[i_cmd.miss_src] <= r_miss[i_cmd.miss_src] + 32'd1;
                end
                r_sub[i_cmd.miss_sub] <= r_sub[i_cmd.miss_sub] + 32'd1;
            end
        end
    end

    // Statistics read; invalid indexes read as zero.
    always_comb begin
        o_set_count        = '0;
        o_met_count        = '0;
        o_missed_count     = '0;
        o_subsystem_misses = '0;
        if (i_stat_src < SRC_LIMIT) begin
            o_set_count    = r_set[i_stat_src];
            o_met_count    = r_met[i_stat_src];
            o_missed_count = r_miss[i_stat_src];
        end
        if ({1'b0, i_stat_sub} < SUB_LIMIT) begin
            o_subsystem_misses = r_sub[i_stat_sub];
        end
    end
endmodule
`default_nettype wire

/* sv/deadline_tracking_table_core.sv */
// Deadline tracking table. One item is accepted at a time. Tick, retire, satisfy and
// query walk the entry memory, reading each entry and then checking and writing it
// back; an announce with a valid source walks it once per subsystem set in the mask.
// Stats and unknown kinds skip the walk. The next item is accepted while a finished
// result still waits in the output register. Depends on dtt_pkg, dtt_entry_ram,
// dtt_counters and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module deadline_tracking_table_core #(
    parameter int TABLE_DEPTH     = dtt_pkg::TABLE_DEPTH_DEF,
    parameter int SUBSYSTEM_COUNT = dtt_pkg::SUBSYSTEM_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_kind,
    input  wire logic [31:0] i_now_time,
    input  wire logic signed [31:0] i_lead_time,
    input  wire logic [2:0]  i_source_id,
    input  wire logic [7:0]  i_consumer_mask,
    input  wire logic [63:0] i_region_key,
    input  wire logic [15:0] i_confidence_level,
    input  wire logic [2:0]  i_subsystem_id,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status_code,
    output logic             o_answer_flag,
    output logic [6:0]       o_fresh_misses,
    output logic [31:0]      o_remaining_time,
    output logic             o_no_deadline,
    output logic [31:0]      o_set_count,
    output logic [31:0]      o_met_count,
    output logic [31:0]      o_missed_count,
    output logic [31:0]      o_subsystem_misses
);
    import dtt_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [3:0]    SUB_END = 4'(SUBSYSTEM_COUNT);

    typedef enum logic [2:0] {S_IDLE, S_SUBSEL, S_RD, S_CK, S_DONE} t_state;

    t_state        r_state;
    t_kind         r_kind;
    logic [31:0]   r_now, r_due;
    logic [2:0]    r_src, r_sub_id;
    logic [7:0]    r_mask;
    logic [63:0]   r_region;
    logic [15:0]   r_conf;
    logic [CW-1:0] r_count, r_idx, r_kept;
    logic [3:0]    r_sub;
    logic [1:0]    r_status;
    logic          r_answer, r_nodl;
    logic [6:0]    r_nmiss;
    logic [31:0]   r_remain;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data, rd_data;
    t_cnt_cmd      cnt_cmd;
    logic [31:0]   st_set, st_met, st_miss, st_sub;
    logic [32:0]   due_sum;
    logic [31:0]   lead_pos;
    logic [2:0]    key_sub;
    logic          hit;

    dtt_entry_ram #(.DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (r_idx[IW-1:0]),
        .o_rd_data (rd_data)
    );

    dtt_counters #(.SUBSYSTEM_COUNT(SUBSYSTEM_COUNT)) u_cnt (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cnt_cmd),
        .i_stat_src         (r_src),
        .i_stat_sub         (r_sub_id),
        .o_set_count        (st_set),
        .o_met_count        (st_met),
        .o_missed_count     (st_miss),
        .o_subsystem_misses (st_sub)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign lead_pos = i_lead_time[31] ? 32'd0 : i_lead_time;
    assign due_sum  = {1'b0, i_now_time} + {1'b0, lead_pos};
    assign key_sub  = (r_kind == KIND_ANNOUNCE) ? r_sub[2:0] : r_sub_id;
    assign hit      = (rd_data.subsystem == key_sub) && (rd_data.region == r_region);

    // Memory writes and counter updates decided from the current step.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx[IW-1:0];
        wr_data = rd_data;
        cnt_cmd = '0;
        cnt_cmd.set_src  = r_src;
        cnt_cmd.met_src  = rd_data.source;
        cnt_cmd.miss_src = rd_data.source;
        cnt_cmd.miss_sub = rd_data.subsystem;
        if (r_state == S_RD && r_idx == r_count && r_kind == KIND_ANNOUNCE
                && r_count < DEPTH_C) begin
            // Insert a new entry at the end of the table.
            wr_en   = 1'b1;
            wr_addr = r_count[IW-1:0];
            wr_data = '{subsystem: r_sub[2:0], region: r_region, due: r_due,
                        confidence: r_conf, source: r_src,
                        satisfied: 1'b0, missed: 1'b0};
            cnt_cmd.inc_set = 1'b1;
        end else if (r_state == S_CK) begin
            unique case (r_kind)
                KIND_ANNOUNCE: begin
                    if (hit && r_due < rd_data.due) begin
                        wr_en = 1'b1;
                        wr_data.due        = r_due;
                        wr_data.confidence = r_conf;
                        wr_data.source     = r_src;
                        wr_data.satisfied  = 1'b0;
                        wr_data.missed     = 1'b0;
                        cnt_cmd.inc_set    = 1'b1;
                    end
                end
                KIND_SATISFY: begin
                    if (hit && !rd_data.satisfied) begin
                        wr_en = 1'b1;
                        wr_data.satisfied = 1'b1;
                        if (!rd_data.missed) begin
                            if (r_now > rd_data.due) begin
                                wr_data.missed   = 1'b1;
                                cnt_cmd.inc_miss = 1'b1;
                            end else begin
                                cnt_cmd.inc_met = 1'b1;
                            end
                        end
                    end
                end
                KIND_TICK: begin
                    if (!rd_data.satisfied && !rd_data.missed && r_now > rd_data.due) begin
                        wr_en = 1'b1;
                        wr_data.missed   = 1'b1;
                        cnt_cmd.inc_miss = 1'b1;
                    end
                end
                KIND_RETIRE: begin
                    if (!rd_data.satisfied && !rd_data.missed && r_kept != r_idx) begin
                        wr_en   = 1'b1;
                        wr_addr = r_kept[IW-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Sequencer with result and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            // A taken result frees the output register unless a new one loads now.
            if (o_valid && i_ready && r_state != S_DONE) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind   <= t_kind'(i_kind);
                        r_now    <= i_now_time;
                        r_due    <= due_sum[32] ? 32'hFFFF_FFFF : due_sum[31:0];
                        r_src    <= i_source_id;
                        r_mask   <= i_consumer_mask;
                        r_region <= i_region_key;
                        r_conf   <= i_confidence_level;
                        r_sub_id <= i_subsystem_id;
                        r_sub    <= '0;
                        r_idx    <= '0;
                        r_kept   <= '0;
                        r_answer <= 1'b0;
                        r_nodl   <= 1'b0;
                        r_nmiss  <= '0;
                        r_remain <= '0;
                        priority if (i_kind == KIND_ANNOUNCE) begin
                            if (i_source_id >= 3'(SOURCE_COUNT)) begin
                                r_status <= STATUS_BAD_SRC;
                                r_state  <= S_DONE;
                            end else begin
                                r_status <= STATUS_OK;
                                r_state  <= S_SUBSEL;
                            end
                        end else if (i_kind == KIND_SATISFY || i_kind == KIND_TICK
                                || i_kind == KIND_QUERY || i_kind == KIND_RETIRE) begin
                            r_status <= STATUS_OK;
                            r_state  <= S_RD;
                        end else begin
                            r_status <= STATUS_OK;
                            r_state  <= S_DONE;
                        end
                    end
                end
                S_SUBSEL: begin
                    // Walk the consumer mask in ascending subsystem order.
                    if (r_sub == SUB_END) begin
                        r_state <= S_DONE;
                    end else if (r_mask[r_sub[2:0]]) begin
                        r_idx   <= '0;
                        r_state <= S_RD;
                    end else begin
                        r_sub <= r_sub + 4'd1;
                    end
                end
                S_RD: begin
                    if (r_idx == r_count) begin
                        // End of the table walk.
                        unique case (r_kind)
                            KIND_ANNOUNCE: begin
                                if (r_count < DEPTH_C) begin
                                    r_count <= r_count + CW'(1);
                                    r_sub   <= r_sub + 4'd1;
                                    r_state <= S_SUBSEL;
                                end else begin
                                    r_status <= STATUS_FULL;
                                    r_state  <= S_DONE;
                                end
                            end
                            KIND_QUERY: begin
                                r_nodl  <= 1'b1;
                                r_state <= S_DONE;
                            end
                            KIND_RETIRE: begin
                                r_count <= r_kept;
                                r_state <= S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end else begin
                        r_state <= S_CK;
                    end
                end
                S_CK: begin
                    r_idx <= r_idx + CW'(1);
                    unique case (r_kind)
                        KIND_ANNOUNCE: begin
                            if (hit) begin
                                r_sub   <= r_sub + 4'd1;
                                r_state <= S_SUBSEL;
                            end else begin
                                r_state <= S_RD;
                            end
                        end
                        KIND_SATISFY: begin
                            if (hit) begin
                                r_answer <= rd_data.satisfied ||
                                            (!rd_data.missed && r_now <= rd_data.due);
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_RD;
                            end
                        end
                        KIND_QUERY: begin
                            if (hit) begin
                                r_nodl   <= rd_data.satisfied;
                                r_remain <= (!rd_data.satisfied && rd_data.due > r_now) ?
                                            rd_data.due - r_now : 32'd0;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_RD;
                            end
                        end
                        KIND_TICK: begin
                            if (!rd_data.satisfied && !rd_data.missed && r_now > rd_data.due) begin
                                r_nmiss <= r_nmiss + 7'd1;
                            end
                            r_state <= S_RD;
                        end
                        KIND_RETIRE: begin
                            if (!rd_data.satisfied && !rd_data.missed) begin
                                r_kept <= r_kept + CW'(1);
                            end
                            r_state <= S_RD;
                        end
                        default: r_state <= S_RD;
                    endcase
                end
                S_DONE: begin
                    // Hand the result over once the output register is free.
                    if (!o_valid || i_ready) begin
                        o_valid            <= 1'b1;
                        o_status_code      <= r_status;
                        o_answer_flag      <= r_answer;
                        o_fresh_misses     <= r_nmiss;
                        o_remaining_time   <= r_remain;
                        o_no_deadline      <= r_nodl;
                        o_set_count        <= (r_kind == KIND_STATS) ? st_set  : 32'd0;
                        o_met_count        <= (r_kind == KIND_STATS) ? st_met  : 32'd0;
                        o_missed_count     <= (r_kind == KIND_STATS) ? st_miss : 32'd0;
                        o_subsystem_misses <= (r_kind == KIND_STATS) ? st_sub  : 32'd0;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `DTT_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= DEPTH_C)
    `DTT_ASSERT_IMPL(a_wr_in_table, i_clk, i_rst_n, wr_en, CW'(wr_addr) <= r_count)
    `DTT_ASSERT_NEXT(a_result_from_done, i_clk, i_rst_n, !o_valid && r_state != S_DONE, !o_valid)
endmodule
`default_nettype wire
